/* rtl/tga_rle_pkg.sv */
// Run-length pixel encoder package: constants, packet type, header and clamp helpers.
// No dependencies; used by the channel interfaces and the core.
package tga_rle_pkg;

    localparam int PIXEL_W   = 32;
    localparam int HEADER_W  = 8;
    localparam int RUN_W     = 8;

    localparam logic [HEADER_W-1:0] HDR_RUN_FLAG  = 8'h80;
    localparam logic [HEADER_W-1:0] HDR_LEN_MASK  = 8'h7F;
    localparam logic [RUN_W-1:0]    MAX_RUN_RESET = 8'd127;
    localparam logic [RUN_W-1:0]    RUN_LIMIT     = 8'd128;

    localparam int FIFO_DEPTH = 4;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [HEADER_W-1:0] header;
        logic [PIXEL_W-1:0]  pixel;
        logic                final_flag;
    } packet_t;

    function automatic logic [HEADER_W-1:0] make_header(input logic [RUN_W-1:0] run_len);
        logic [RUN_W-1:0] len;
        len = (run_len == '0) ? RUN_W'(1) : run_len;
        return HDR_RUN_FLAG | ((len - RUN_W'(1)) & HDR_LEN_MASK);
    endfunction

    function automatic logic [RUN_W-1:0] clamp_max(input logic [RUN_W-1:0] max_run);
        if (max_run == '0)
            return RUN_W'(1);
        else if (max_run > RUN_LIMIT)
            return RUN_LIMIT;
        else
            return max_run;
    endfunction

endpackage

/* rtl/tga_rle_pix_if.sv */
// Pixel stream channel: valid/ready handshake with pixel and end-of-image mark.
// Depends on tga_rle_pkg.
interface tga_rle_pix_if
    import tga_rle_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               image_end;

    modport source (output valid, output pixel, output image_end, input ready);
    modport sink   (input valid, input pixel, input image_end, output ready);
endinterface

/* rtl/tga_rle_pkt_if.sv */
// Packet stream channel: valid/ready handshake with run packet header, pixel and final mark.
// Depends on tga_rle_pkg.
interface tga_rle_pkt_if
    import tga_rle_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HEADER_W-1:0] packet_header;
    logic [PIXEL_W-1:0]  packet_pixel;
    logic                final_packet;

    modport source (output valid, output packet_header, output packet_pixel,
                    output final_packet, input ready);
    modport sink   (input valid, input packet_header, input packet_pixel,
                    input final_packet, output ready);
endinterface

/* rtl/tga_run_length_pixel_encoder_core.sv */
// Top level of the run-length pixel encoder: run tracking and a small packet queue.
// Depends on tga_rle_pkg, tga_rle_pix_if and tga_rle_pkt_if.
//
//   Channel        Direction  Handshake          Payload
//   pixels         sink       valid/ready        pixel[31:0], image_end
//   packets        source     valid/ready        packet_header[7:0], packet_pixel[31:0],
//                                                final_packet
//   max_run        write      max_run_we         max_run_wdata[7:0]
//
// One pixel is taken per cycle while pixels.ready is high; its packets enter a
// four-entry queue in the same edge and the head packet is visible on the next cycle.
// A pixel yields zero, one or two packets; the packet port drains one per cycle while packets.ready is high.
// pixels.ready is high while the queue holds at most two packets.
// Reset clears the open run, the queue and sets max_run to 127.
module tga_run_length_pixel_encoder_core
    import tga_rle_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tga_rle_pix_if.sink         pixels,
    tga_rle_pkt_if.source       packets,
    input  logic                max_run_we,
    input  logic [RUN_W-1:0]    max_run_wdata
);

    logic [RUN_W-1:0]   max_run_reg;
    logic [PIXEL_W-1:0] held_pixel_reg, held_pixel_next;
    logic [RUN_W-1:0]   run_count_reg, run_count_next;
    packet_t            fifo_reg [FIFO_DEPTH];
    packet_t            fifo_next [FIFO_DEPTH];
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               in_accept;
    logic               pop;
    logic               close_run;
    logic [RUN_W-1:0]   eff_max;
    packet_t            close_pkt, final_pkt, pkt0, pkt1;
    logic [1:0]         push_num;
    logic [CNT_W-1:0]   base;
    logic [IDX_W-1:0]   idx0, idx1;

    assign pixels.ready  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_accept     = pixels.valid && pixels.ready;
    assign pop           = packets.valid && packets.ready;
    assign eff_max       = clamp_max(max_run_reg);

    assign packets.valid         = (count_reg != '0);
    assign packets.packet_header = fifo_reg[0].header;
    assign packets.packet_pixel  = fifo_reg[0].pixel;
    assign packets.final_packet  = fifo_reg[0].final_flag;

    always_comb
    begin
        held_pixel_next = held_pixel_reg;
        run_count_next  = run_count_reg;
        close_run       = 1'b0;
        close_pkt       = '{header: make_header(run_count_reg), pixel: held_pixel_reg,
                            final_flag: 1'b0};
        if (run_count_reg == '0)
        begin
            held_pixel_next = pixels.pixel;
            run_count_next  = RUN_W'(1);
        end
        else if (pixels.pixel == held_pixel_reg && run_count_reg < eff_max)
        begin
            run_count_next = run_count_reg + RUN_W'(1);
        end
        else
        begin
            close_run       = 1'b1;
            held_pixel_next = pixels.pixel;
            run_count_next  = RUN_W'(1);
        end
        final_pkt = '{header: make_header(run_count_next), pixel: held_pixel_next,
                      final_flag: 1'b1};
        if (pixels.image_end)
            run_count_next = '0;
    end

    always_comb
    begin
        pkt0     = close_run ? close_pkt : final_pkt;
        pkt1     = final_pkt;
        push_num = in_accept ? (2'(close_run) + 2'(pixels.image_end)) : 2'd0;
        base     = count_reg - CNT_W'(pop);
        idx0     = base[IDX_W-1:0];
        idx1     = idx0 + IDX_W'(1);
        fifo_next = fifo_reg;
        if (pop)
        begin
            for (int i = 0; i < FIFO_DEPTH - 1; i++)
                fifo_next[i] = fifo_reg[i+1];
        end
        if (push_num != 2'd0)
            fifo_next[idx0] = pkt0;
        if (push_num == 2'd2)
            fifo_next[idx1] = pkt1;
        count_next = base + CNT_W'(push_num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg    <= MAX_RUN_RESET;
            held_pixel_reg <= '0;
            run_count_reg  <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (max_run_we)
                max_run_reg <= max_run_wdata;
            if (in_accept)
            begin
                held_pixel_reg <= held_pixel_next;
                run_count_reg  <= run_count_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fifo_reg <= fifo_next;
    end

`ifndef SYNTH
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg <= RUN_LIMIT)
        else $error("open run longer than the header can encode");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && pixels.image_end |=> run_count_reg == '0)
        else $error("end of image left a run open");

    a_run_opens: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !pixels.image_end |=> run_count_reg != '0)
        else $error("pixel did not leave an open run");

    a_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("packet queue overflow");

    a_header_flag: assert property (@(posedge clk) disable iff (!rst_n)
        packets.valid |-> packets.packet_header[7])
        else $error("packet header lacks run flag");
`endif

endmodule

/* dv/tb.sv */
// Testbench for tga_run_length_pixel_encoder_core: directed table, then random image streams.
// Packets are checked against typed table entries or a run-length predictor held here;
// needs tga_rle_pkg and the pixel and packet channel interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_rle_pkg::*;

    typedef struct {
        bit                 set_max;
        logic [RUN_W-1:0]   max_value;
        logic [PIXEL_W-1:0] pixel;
        logic               image_end;
        int                 typed_count;
        packet_t [1:0]      typed;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic max_run_we;
    logic [RUN_W-1:0] max_run_wdata;

    tga_rle_pix_if pix_ch ();
    tga_rle_pkt_if pkt_ch ();

    tga_run_length_pixel_encoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixels        (pix_ch),
        .packets       (pkt_ch),
        .max_run_we    (max_run_we),
        .max_run_wdata (max_run_wdata)
    );

    logic [PIXEL_W-1:0] run_pixel;
    logic [RUN_W-1:0]   run_length;
    logic [RUN_W-1:0]   max_run_reg;
    packet_t            expected_packets[$];
    stim_row_t          directed_rows[$];
    int                 fail_count;
    int                 burst_left;
    int                 sink_mode;
    int                 mode_left;
    int                 stall_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [RUN_W-1:0] run_ceiling(input logic [RUN_W-1:0] max_value);
        if (max_value == 8'd0)
            return 8'd1;
        if (max_value > 8'd128)
            return 8'd128;
        return max_value;
    endfunction

    function automatic packet_t close_run(input logic final_flag);
        packet_t pk;
        logic [RUN_W-1:0] len;
        len = (run_length == 8'd0) ? 8'd1 : run_length;
        pk.header     = HDR_RUN_FLAG | ((len - 8'd1) & HDR_LEN_MASK);
        pk.pixel      = run_pixel;
        pk.final_flag = final_flag;
        return pk;
    endfunction

    function automatic int encode_pixel(input logic [PIXEL_W-1:0] px, input logic last,
                                        output packet_t [1:0] pk);
        int n;
        n  = 0;
        pk = '0;
        if (run_length == 8'd0)
        begin
            run_pixel  = px;
            run_length = 8'd1;
        end
        else if (px == run_pixel && run_length < run_ceiling(max_run_reg))
        begin
            run_length = run_length + 8'd1;
        end
        else
        begin
            pk[n] = close_run(1'b0);
            n++;
            run_pixel  = px;
            run_length = 8'd1;
        end
        if (last)
        begin
            pk[n] = close_run(1'b1);
            n++;
            run_length = 8'd0;
        end
        return n;
    endfunction

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic add_pixel(input logic [PIXEL_W-1:0] px, input logic last, input int cnt,
                             input packet_t p0, input packet_t p1);
        stim_row_t row;
        row.set_max     = 1'b0;
        row.max_value   = '0;
        row.pixel       = px;
        row.image_end   = last;
        row.typed_count = cnt;
        row.typed[0]    = p0;
        row.typed[1]    = p1;
        directed_rows.push_back(row);
    endtask

    task automatic add_max(input logic [RUN_W-1:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.set_max     = 1'b1;
        row.max_value   = value;
        row.typed_count = -1;
        directed_rows.push_back(row);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic last,
                              input int typed_count, input packet_t [1:0] typed);
        packet_t [1:0] predicted;
        int n;
        int k;
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel     <= px;
        pix_ch.image_end <= last;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        n = encode_pixel(px, last, predicted);
        if (typed_count >= 0)
        begin
            for (k = 0; k < typed_count; k++)
                expected_packets.push_back(typed[k]);
        end
        else
        begin
            for (k = 0; k < n; k++)
                expected_packets.push_back(predicted[k]);
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 20);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_max_run(input logic [RUN_W-1:0] value);
        pix_ch.valid <= 1'b0;
        while (expected_packets.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        max_run_we    <= 1'b1;
        max_run_wdata <= value;
        @(posedge clk);
        max_run_we  <= 1'b0;
        max_run_reg = value;
    endtask

    task automatic run_phase(input logic [RUN_W-1:0] max_value, input int budget);
        logic [PIXEL_W-1:0] palette[4];
        logic [PIXEL_W-1:0] px;
        logic [RUN_W-1:0]   ceiling;
        logic               close_image;
        logic               last;
        int sent;
        int len;
        int pick;
        int k;
        write_max_run(max_value);
        for (k = 0; k < 4; k++)
            palette[k] = $urandom;
        sent = 0;
        while (sent < budget)
        begin
            ceiling = run_ceiling(max_run_reg);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                len = $urandom_range(1, 4);
            else if (pick < 8)
                len = $urandom_range((ceiling > 1) ? ceiling - 1 : 1, ceiling + 1);
            else if (pick == 8)
                len = $urandom_range(1, 2 * ceiling + 2);
            else
                len = 1;
            px = $urandom_range(0, 1) ? palette[$urandom_range(0, 3)] : $urandom;
            close_image = ($urandom_range(0, 7) == 0);
            for (k = 0; k < len; k++)
            begin
                last = (k == len - 1) ? close_image : ($urandom_range(0, 59) == 0);
                send_pixel(px, last, -1, '0);
                pace();
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : packet_sink
        packet_t seen;
        packet_t want;
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
        begin
            seen = {pkt_ch.packet_header, pkt_ch.packet_pixel, pkt_ch.final_packet};
            if (expected_packets.size() == 0)
            begin
                flag_failure($sformatf("unexpected packet: header=%02h pixel=%08h final=%0b",
                                       seen.header, seen.pixel, seen.final_flag));
            end
            else
            begin
                want = expected_packets.pop_front();
                if (seen.header !== want.header || seen.pixel !== want.pixel
                    || seen.final_flag !== want.final_flag)
                    flag_failure($sformatf({"packet mismatch: expected header=%02h ",
                                            "pixel=%08h final=%0b, got header=%02h ",
                                            "pixel=%08h final=%0b"},
                                           want.header, want.pixel, want.final_flag,
                                           seen.header, seen.pixel, seen.final_flag));
            end
        end
        if (mode_left == 0)
        begin
            sink_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (sink_mode)
            0: pkt_ch.ready <= 1'b1;
            1: pkt_ch.ready <= ($urandom_range(0, 3) != 0);
            2: pkt_ch.ready <= $urandom_range(0, 1);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    pkt_ch.ready <= 1'b0;
                end
                else
                begin
                    pkt_ch.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 8);
                end
            end
        endcase
    end

    initial
    begin
        rst_n            = 1'b0;
        pix_ch.valid     = 1'b0;
        pix_ch.pixel     = '0;
        pix_ch.image_end = 1'b0;
        pkt_ch.ready     = 1'b0;
        max_run_we       = 1'b0;
        max_run_wdata    = '0;
        run_pixel        = '0;
        run_length       = '0;
        max_run_reg      = MAX_RUN_RESET;
        fail_count       = 0;
        burst_left       = $urandom_range(1, 20);
        sink_mode        = 0;
        mode_left        = 0;
        stall_left       = 0;

        add_pixel(32'h0000_0000, 1'b1, 1, {8'h80, 32'h0000_0000, 1'b1}, '0);
        add_pixel(32'hFFFF_FFFF, 1'b0, 0, '0, '0);
        add_pixel(32'hFFFF_FFFF, 1'b1, 1, {8'h81, 32'hFFFF_FFFF, 1'b1}, '0);
        add_pixel(32'h1234_5678, 1'b0, 0, '0, '0);
        add_pixel(32'h9ABC_DEF0, 1'b1, 2, {8'h80, 32'h1234_5678, 1'b0},
                  {8'h80, 32'h9ABC_DEF0, 1'b1});
        add_pixel(32'h8000_0000, 1'b0, -1, '0, '0);
        add_pixel(32'h8000_0000, 1'b0, -1, '0, '0);
        add_pixel(32'h0000_0001, 1'b0, -1, '0, '0);
        add_pixel(32'h0000_0001, 1'b1, -1, '0, '0);
        add_max(8'd0);
        add_pixel(32'h0000_AAAA, 1'b0, 0, '0, '0);
        add_pixel(32'h0000_AAAA, 1'b0, 1, {8'h80, 32'h0000_AAAA, 1'b0}, '0);
        add_pixel(32'h0000_AAAA, 1'b1, 2, {8'h80, 32'h0000_AAAA, 1'b0},
                  {8'h80, 32'h0000_AAAA, 1'b1});
        add_max(8'd255);
        add_pixel(32'h5555_5555, 1'b0, -1, '0, '0);
        add_pixel(32'h5555_5555, 1'b0, -1, '0, '0);
        add_pixel(32'h5555_5555, 1'b0, -1, '0, '0);
        add_max(8'd2);
        add_pixel(32'h5555_5555, 1'b0, 1, {8'h82, 32'h5555_5555, 1'b0}, '0);
        add_pixel(32'h5555_5555, 1'b0, -1, '0, '0);
        add_pixel(32'h5555_5555, 1'b1, -1, '0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].set_max)
                write_max_run(directed_rows[r].max_value);
            else
            begin
                send_pixel(directed_rows[r].pixel, directed_rows[r].image_end,
                           directed_rows[r].typed_count, directed_rows[r].typed);
                pace();
            end
        end

        run_phase(8'd1, 175);
        run_phase(8'd128, 175);
        run_phase(8'd0, 175);
        run_phase(8'd255, 175);
        run_phase(8'd2, 175);
        run_phase(8'd3, 175);
        run_phase(8'd127, 175);
        run_phase(8'd129, 175);
        run_phase(8'($urandom_range(1, 128)), 175);
        run_phase(8'($urandom_range(0, 255)), 175);

        pix_ch.valid <= 1'b0;
        while (expected_packets.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_packets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
